@@ rtl/assert_macros.svh @@
// Assertion macros used by the parser top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active (active low).
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is active (active low).
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/t2u_pkg.sv @@
// Types, character codes and decode helpers for the text to unsigned parser.
`default_nettype none

package t2u_pkg;

  localparam int unsigned CHAR_BITS = 8;
  localparam int unsigned BASE_BITS = 6;

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [BASE_BITS-1:0] base_t;

  localparam base_t BASE_RESET  = base_t'(10);
  localparam base_t BASE_DETECT = base_t'(0);
  localparam base_t BASE_BAD    = base_t'(1);
  localparam base_t BASE_OCT    = base_t'(8);
  localparam base_t BASE_DEC    = base_t'(10);
  localparam base_t BASE_HEX    = base_t'(16);
  localparam base_t BASE_MAX    = base_t'(36);
  // digit code for a byte that is no digit at all; never below a legal base
  localparam base_t DIGIT_NONE  = base_t'(36);

  localparam char_t CH_ZERO  = char_t'(8'h30);
  localparam char_t CH_NINE  = char_t'(8'h39);
  localparam char_t CH_LA    = char_t'(8'h61);
  localparam char_t CH_LZ    = char_t'(8'h7a);
  localparam char_t CH_UA    = char_t'(8'h41);
  localparam char_t CH_UZ    = char_t'(8'h5a);
  localparam char_t CH_LX    = char_t'(8'h78);
  localparam char_t CH_UX    = char_t'(8'h58);
  localparam char_t CH_MINUS = char_t'(8'h2d);
  localparam char_t CH_PLUS  = char_t'(8'h2b);
  localparam char_t CH_SPACE = char_t'(8'h20);
  localparam char_t CH_TAB   = char_t'(8'h09);
  localparam char_t CH_CR    = char_t'(8'h0d);

  function automatic logic is_space(input char_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic base_t digit_of(input char_t c);
    base_t d;
    d = DIGIT_NONE;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d = base_t'(c - CH_ZERO);
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      d = base_t'(c - CH_LA) + BASE_DEC;
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      d = base_t'(c - CH_UA) + BASE_DEC;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

@@ rtl/t2u_in_if.sv @@
// Character input channel: valid/ready with one byte and a start flag.
`default_nettype none

interface t2u_in_if;
  import t2u_pkg::*;

  logic  valid;
  logic  ready;
  char_t character;
  logic  start_of_string;

  modport source (output valid, output character, output start_of_string, input ready);
  modport sink   (input valid, input character, input start_of_string, output ready);
endinterface

`default_nettype wire

@@ rtl/t2u_res_if.sv @@
// Result channel: valid/ready with converted value, end offset and bad base flag.
`default_nettype none

interface t2u_res_if #(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned OFFSET_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  value;
  logic [OFFSET_BITS-1:0] end_offset;
  logic                   bad_base;

  modport source (output valid, output value, output end_offset, output bad_base, input ready);
  modport sink   (input valid, input value, input end_offset, input bad_base, output ready);
endinterface

`default_nettype wire

@@ rtl/text_to_unsigned_parser.sv @@
// Top level: streaming strtoul-style text to unsigned integer parser.
//
// Usage:
//  - txt_i carries one byte per transaction; start_of_string marks the first
//    byte of a string and clears all parse state. Bytes arriving while no
//    string is open (after reset or after a result) are consumed and dropped.
//  - res_o carries at most one transaction per string: value, end_offset and
//    bad_base, produced at the first byte that does not fit the number.
//  - cfg_we_i/cfg_data_i write number_base (reset 10, 0 = detect from prefix).
//    The base is sampled on each start byte; write it only while idle.
//  - A byte accepted on txt_i waits in the input register, is decoded from
//    there, and its result is offered on res_o from the result register.
//  - Throughput: one byte per cycle unless res_o stalls. The cycle is set
//    by the digit path: decode, a VALUE_BITS x 6 multiply by the base and one add.
//  - When res_o stalls with a result pending, the decode stage waits and
//    txt_i holds ready low once the input register is full too.
//  - Reset (rst_ni, async, active low) empties both registers and leaves the
//    parser waiting for a start byte; the base returns to 10.
//  - A bad base (1 or above 36) gives its result on the start byte itself.
`default_nettype none
`include "assert_macros.svh"

module text_to_unsigned_parser #(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire t2u_pkg::base_t cfg_data_i,
  input  wire                 cfg_we_i,
  t2u_in_if.sink              txt_i,
  t2u_res_if.source           res_o
);
  import t2u_pkg::*;

  typedef enum logic [1:0] {
    PH_WS,
    PH_PREFIX,
    PH_X,
    PH_DIGITS
  } phase_e;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  // configuration
  base_t number_base_q;

  // input register
  logic  in_vld_q;
  char_t char_q;
  logic  sos_q;

  // parse state
  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  base_t                  base_q, base_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
  logic                   fin_q, fin_d;
  logic                   seen_q, seen_d;
  logic                   afterx_q, afterx_d;
  logic [OFFSET_BITS-1:0] fb_q, fb_d;

  // result register
  logic                   out_vld_q;
  logic [VALUE_BITS-1:0]  val_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic                   bad_q;

  logic                   proc_fire;
  logic                   emit;
  logic [VALUE_BITS-1:0]  emit_val;
  logic [OFFSET_BITS-1:0] emit_off;
  logic                   emit_bad;
  logic                   handled;
  base_t                  dig;
  logic [VALUE_BITS-1:0]  mul_acc;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  // decode stage runs whenever the result register has room
  assign proc_fire   = in_vld_q && (!out_vld_q || res_o.ready);
  assign txt_i.ready = !in_vld_q || proc_fire;

  assign res_o.valid      = out_vld_q;
  assign res_o.value      = val_q;
  assign res_o.end_offset = off_q;
  assign res_o.bad_base   = bad_q;

  assign dig = digit_of(char_q);

  // one character of the strtoul walk; phases fall through like the C loop
  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    base_d   = base_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    seen_d   = seen_q;
    afterx_d = afterx_q;
    fb_d     = fb_q;
    emit     = 1'b0;
    emit_val = '0;
    emit_off = '0;
    emit_bad = 1'b0;
    handled  = 1'b0;
    mul_acc  = '0;

    if (sos_q) begin
      phase_d  = PH_WS;
      neg_d    = 1'b0;
      acc_d    = '0;
      cnt_d    = '0;
      seen_d   = 1'b0;
      afterx_d = 1'b0;
      fb_d     = '0;
      fin_d    = 1'b0;
      base_d   = number_base_q;
      if ((base_d == BASE_BAD) || (base_d > BASE_MAX)) begin
        emit     = 1'b1;
        emit_val = '1;
        emit_bad = 1'b1;
        fin_d    = 1'b1;
      end
    end

    if (!fin_d) begin
      if (phase_d == PH_WS) begin
        if (is_space(char_q)) begin
          cnt_d   = sat_inc(cnt_d);
          handled = 1'b1;
        end else begin
          phase_d = PH_PREFIX;
          if (char_q == CH_MINUS) begin
            neg_d   = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            handled = 1'b1;
          end else if (char_q == CH_PLUS) begin
            cnt_d   = sat_inc(cnt_d);
            handled = 1'b1;
          end
        end
      end

      if (!handled && (phase_d == PH_PREFIX)) begin
        phase_d = PH_DIGITS;
        if ((base_d == BASE_DETECT) || (base_d == BASE_HEX)) begin
          if (char_q == CH_ZERO) begin
            if (base_d == BASE_DETECT) begin
              base_d = BASE_OCT;
            end
            seen_d  = 1'b1;
            cnt_d   = sat_inc(cnt_d);
            phase_d = PH_X;
            handled = 1'b1;
          end else if (base_d == BASE_DETECT) begin
            base_d = BASE_DEC;
          end
        end
      end

      if (!handled && (phase_d == PH_X)) begin
        phase_d = PH_DIGITS;
        if ((char_q == CH_LX) || (char_q == CH_UX)) begin
          base_d   = BASE_HEX;
          fb_d     = cnt_d;
          seen_d   = 1'b0;
          afterx_d = 1'b1;
          cnt_d    = sat_inc(cnt_d);
          handled  = 1'b1;
        end
      end

      if (!handled) begin
        if (dig < base_d) begin
          mul_acc = VALUE_BITS'(acc_d * {{(VALUE_BITS-BASE_BITS){1'b0}}, base_d});
          acc_d   = mul_acc + VALUE_BITS'(dig);
          seen_d  = 1'b1;
          cnt_d   = sat_inc(cnt_d);
        end else begin
          emit  = 1'b1;
          fin_d = 1'b1;
          if (seen_d) begin
            emit_val = neg_d ? ('0 - acc_d) : acc_d;
            emit_off = cnt_d;
          end else if (afterx_d) begin
            emit_off = fb_d;
          end
        end
      end
    end
  end

  // state, input register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BASE_RESET;
      in_vld_q      <= 1'b0;
      char_q        <= '0;
      sos_q         <= 1'b0;
      out_vld_q     <= 1'b0;
      val_q         <= '0;
      off_q         <= '0;
      bad_q         <= 1'b0;
      phase_q       <= PH_WS;
      neg_q         <= 1'b0;
      base_q        <= BASE_DETECT;
      acc_q         <= '0;
      cnt_q         <= '0;
      fin_q         <= 1'b1;
      seen_q        <= 1'b0;
      afterx_q      <= 1'b0;
      fb_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        number_base_q <= cfg_data_i;
      end

      if (txt_i.valid && txt_i.ready) begin
        in_vld_q <= 1'b1;
        char_q   <= txt_i.character;
        sos_q    <= txt_i.start_of_string;
      end else if (proc_fire) begin
        in_vld_q <= 1'b0;
      end

      if (proc_fire) begin
        phase_q  <= phase_d;
        neg_q    <= neg_d;
        base_q   <= base_d;
        acc_q    <= acc_d;
        cnt_q    <= cnt_d;
        fin_q    <= fin_d;
        seen_q   <= seen_d;
        afterx_q <= afterx_d;
        fb_q     <= fb_d;
      end

      if (proc_fire && emit) begin
        out_vld_q <= 1'b1;
        val_q     <= emit_val;
        off_q     <= emit_off;
        bad_q     <= emit_bad;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // a bad base result carries all ones and no consumed characters
  `ASSERT_IMPL(a_bad_base_shape, clk_i, rst_ni, res_o.valid && res_o.bad_base, (res_o.value == '1) && (res_o.end_offset == '0))
  // a held character is never dropped without being decoded
  `ASSERT_NEXT(a_in_held, clk_i, rst_ni, in_vld_q && !proc_fire, in_vld_q)
  // no result once a string is closed until a new start byte arrives
  `ASSERT_IMPL(a_no_emit_closed, clk_i, rst_ni, proc_fire && fin_q && !sos_q, !emit)

endmodule

`default_nettype wire
